/* rtl/dqzz_pkg.sv */
// dqzz_pkg: shared types, constants and the zig-zag to raster map
// for the dequantize/de-zigzag block; depends on nothing
`default_nettype none

package dqzz_pkg;

  localparam int BLOCK_LEN = 64;
  localparam int POS_W     = 6;
  localparam int CNT_W     = 7;
  localparam int COEF_W    = 16;
  localparam int STEP_W    = 8;
  localparam int VALUE_W   = 16;
  localparam int PROD_W    = COEF_W + STEP_W + 1;

  typedef logic [POS_W-1:0]          pos_t;
  typedef logic [CNT_W-1:0]          cnt_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic [STEP_W-1:0]         step_t;
  typedef logic signed [VALUE_W-1:0] value_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic wr_en;    // store the dequantized coefficient
    pos_t wr_pos;   // zig-zag position of that coefficient
    logic rd_en;    // fetch one raster entry from the block store
    pos_t rd_addr;  // raster address of that fetch
    logic out_load; // move fetched entry into the output register
    logic out_last; // fetched entry is the final one of the block
  } dp_cmd_t;

  // standard jpeg zig-zag index to raster index
  function automatic pos_t zz_to_raster(input pos_t zz);
    pos_t r;
    case (zz)
      6'd0:  r = 6'd0;   6'd1:  r = 6'd1;   6'd2:  r = 6'd8;   6'd3:  r = 6'd16;
      6'd4:  r = 6'd9;   6'd5:  r = 6'd2;   6'd6:  r = 6'd3;   6'd7:  r = 6'd10;
      6'd8:  r = 6'd17;  6'd9:  r = 6'd24;  6'd10: r = 6'd32;  6'd11: r = 6'd25;
      6'd12: r = 6'd18;  6'd13: r = 6'd11;  6'd14: r = 6'd4;   6'd15: r = 6'd5;
      6'd16: r = 6'd12;  6'd17: r = 6'd19;  6'd18: r = 6'd26;  6'd19: r = 6'd33;
      6'd20: r = 6'd40;  6'd21: r = 6'd48;  6'd22: r = 6'd41;  6'd23: r = 6'd34;
      6'd24: r = 6'd27;  6'd25: r = 6'd20;  6'd26: r = 6'd13;  6'd27: r = 6'd6;
      6'd28: r = 6'd7;   6'd29: r = 6'd14;  6'd30: r = 6'd21;  6'd31: r = 6'd28;
      6'd32: r = 6'd35;  6'd33: r = 6'd42;  6'd34: r = 6'd49;  6'd35: r = 6'd56;
      6'd36: r = 6'd57;  6'd37: r = 6'd50;  6'd38: r = 6'd43;  6'd39: r = 6'd36;
      6'd40: r = 6'd29;  6'd41: r = 6'd22;  6'd42: r = 6'd15;  6'd43: r = 6'd23;
      6'd44: r = 6'd30;  6'd45: r = 6'd37;  6'd46: r = 6'd44;  6'd47: r = 6'd51;
      6'd48: r = 6'd58;  6'd49: r = 6'd59;  6'd50: r = 6'd52;  6'd51: r = 6'd45;
      6'd52: r = 6'd38;  6'd53: r = 6'd31;  6'd54: r = 6'd39;  6'd55: r = 6'd46;
      6'd56: r = 6'd53;  6'd57: r = 6'd60;  6'd58: r = 6'd61;  6'd59: r = 6'd54;
      6'd60: r = 6'd47;  6'd61: r = 6'd55;  6'd62: r = 6'd62;  6'd63: r = 6'd63;
      default: r = zz;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/dqzz_if.sv */
// dqzz_if: valid/ready channel interfaces for coefficients in and values out
// depends on dqzz_pkg
`default_nettype none

interface dqzz_in_if;
  logic                  valid;
  logic                  ready;
  dqzz_pkg::coef_t       coefficient;
  dqzz_pkg::step_t       quant_step;

  modport source (output valid, output coefficient, output quant_step, input ready);
  modport sink   (input valid, input coefficient, input quant_step, output ready);
endinterface

interface dqzz_out_if;
  logic                  valid;
  logic                  ready;
  dqzz_pkg::value_t      value;
  logic                  last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

`default_nettype wire

/* rtl/dqzz_ram.sv */
// dqzz_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module dqzz_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port, holds when idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/dqzz_datapath.sv */
// dqzz_datapath: multiply and saturate, block store, output payload register
// depends on dqzz_pkg and dqzz_ram
`default_nettype none

module dqzz_datapath (
  input  wire logic              clk,
  input  wire dqzz_pkg::dp_cmd_t cmd,
  input  wire dqzz_pkg::coef_t   coefficient,
  input  wire dqzz_pkg::step_t   quant_step,
  output      dqzz_pkg::value_t  out_value,
  output      logic              out_last
);

  logic signed [dqzz_pkg::PROD_W-1:0] prod;
  dqzz_pkg::value_t                   sat;
  dqzz_pkg::pos_t                     waddr;
  logic [dqzz_pkg::VALUE_W-1:0]       rdata;
  dqzz_pkg::value_t                   value_r;
  logic                               last_r;

  // signed coefficient times unsigned step
  assign prod = dqzz_pkg::PROD_W'(coefficient) *
                $signed({1'b0, quant_step});

  // clamp to the signed 16-bit range
  always_comb begin
    if (prod[dqzz_pkg::PROD_W-1:dqzz_pkg::VALUE_W-1] == '0 ||
        prod[dqzz_pkg::PROD_W-1:dqzz_pkg::VALUE_W-1] == '1) begin
      sat = prod[dqzz_pkg::VALUE_W-1:0];
    end else if (prod[dqzz_pkg::PROD_W-1]) begin
      sat = {1'b1, {(dqzz_pkg::VALUE_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(dqzz_pkg::VALUE_W-1){1'b1}}};
    end
  end

  assign waddr = dqzz_pkg::zz_to_raster(cmd.wr_pos);

  // block store in raster order
  dqzz_ram #(
    .WIDTH (dqzz_pkg::VALUE_W),
    .DEPTH (dqzz_pkg::BLOCK_LEN)
  ) u_store (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (waddr),
    .wdata (sat),
    .re    (cmd.rd_en),
    .raddr (cmd.rd_addr),
    .rdata (rdata)
  );

  // output payload register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      value_r <= rdata;
      last_r  <= cmd.out_last;
    end
  end

  assign out_value = value_r;
  assign out_last  = last_r;

endmodule

`default_nettype wire

/* rtl/dqzz_ctrl.sv */
// dqzz_ctrl: load/drain state machine, position and readout counters,
// handshake flags; depends on dqzz_pkg
`default_nettype none

module dqzz_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_ready,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      dqzz_pkg::dp_cmd_t cmd
);

  localparam logic ST_LOAD  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic           state_r,     state_nxt;
  dqzz_pkg::pos_t pos_r,       pos_nxt;
  dqzz_pkg::cnt_t rd_cnt_r,    rd_cnt_nxt;
  logic           pend_r,      pend_nxt;
  logic           pend_last_r, pend_last_nxt;
  logic           out_valid_r, out_valid_nxt;

  logic in_fire;
  logic out_fire;
  logic out_load;
  logic rd_en;

  assign in_ready = (state_r == ST_LOAD);
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;

  // move a fetched entry forward when the output register frees up
  assign out_load = pend_r && (!out_valid_r || out_ready);

  // fetch the next raster entry when the fetch stage is or becomes empty
  assign rd_en = (state_r == ST_DRAIN) &&
                 (rd_cnt_r != dqzz_pkg::CNT_W'(dqzz_pkg::BLOCK_LEN)) &&
                 (!pend_r || out_load);

  // next-state logic
  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    rd_cnt_nxt    = rd_cnt_r;
    pend_nxt      = pend_r;
    pend_last_nxt = pend_last_r;
    out_valid_nxt = out_valid_r;

    case (state_r)
      ST_LOAD: begin
        if (in_fire) begin
          pos_nxt = pos_r + 1'b1;
          if (pos_r == dqzz_pkg::POS_W'(dqzz_pkg::BLOCK_LEN - 1)) begin
            state_nxt  = ST_DRAIN;
            rd_cnt_nxt = '0;
          end
        end
      end
      ST_DRAIN: begin
        if (rd_en) begin
          rd_cnt_nxt = rd_cnt_r + 1'b1;
        end
        // block done once its final entry reaches the output register
        if (out_load && pend_last_r) begin
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase

    // fetch stage occupancy
    if (rd_en) begin
      pend_nxt      = 1'b1;
      pend_last_nxt = (rd_cnt_r == dqzz_pkg::CNT_W'(dqzz_pkg::BLOCK_LEN - 1));
    end else if (out_load) begin
      pend_nxt = 1'b0;
    end

    // output register occupancy
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      pos_r       <= '0;
      rd_cnt_r    <= '0;
      pend_r      <= 1'b0;
      pend_last_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      pend_r      <= pend_nxt;
      pend_last_r <= pend_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // datapath commands
  always_comb begin
    cmd.wr_en    = in_fire;
    cmd.wr_pos   = pos_r;
    cmd.rd_en    = rd_en;
    cmd.rd_addr  = rd_cnt_r[dqzz_pkg::POS_W-1:0];
    cmd.out_load = out_load;
    cmd.out_last = pend_last_r;
  end

endmodule

`default_nettype wire

/* rtl/dequantize_dezigzag.sv */
// dequantize_dezigzag: top level, joins controller and datapath
// depends on dqzz_pkg, dqzz_if, dqzz_ctrl, dqzz_datapath
`default_nettype none

// JPEG inverse quantization with zig-zag reordering. Each input transaction
// carries one coefficient of an 8x8 block in zig-zag order with its
// quantization step; the saturated product is written into a 64-entry block
// store at its raster position. The block alternates between two phases that
// share the single block store: a load phase that accepts one coefficient per
// cycle, then a readout phase during which in_chan.ready is low and the 64
// values leave in raster order, one per cycle while the sink is ready, with
// last set on the final one. Once the 64th coefficient is accepted, each
// value passes from the registered read port of the block store into the
// output register before it is offered. Loading of the next block starts as
// soon as the final value of the current block sits in the output register.

module dequantize_dezigzag (
  input wire logic    clk,
  input wire logic    rst_n,
  dqzz_in_if.sink     in_chan,
  dqzz_out_if.source  out_chan
);

  dqzz_pkg::dp_cmd_t cmd;

  // controller
  dqzz_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd)
  );

  // datapath
  dqzz_datapath u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .coefficient (in_chan.coefficient),
    .quant_step  (in_chan.quant_step),
    .out_value   (out_chan.value),
    .out_last    (out_chan.last)
  );

endmodule

`default_nettype wire
